>>> design/colla_pkg.sv
// Shared types and constants for the control ownership lease arbiter.
`default_nettype none

package colla_pkg;

    // Request kinds carried on s_tuser
    typedef enum logic [2:0] {
        OP_CLAIM     = 3'd0,
        OP_AUTHORIZE = 3'd1,
        OP_HEARTBEAT = 3'd2,
        OP_RELEASE   = 3'd3,
        OP_QUERY     = 3'd4
    } op_e_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_STALE     = 3'd1,
        ST_BUSY      = 3'd2,
        ST_NOT_OWNER = 3'd3,
        ST_INVALID   = 3'd4
    } status_e_t;

    // Control source codes
    localparam logic [2:0] SRC_NONE      = 3'd0;
    localparam logic [2:0] SRC_REST      = 3'd1;
    localparam logic [2:0] SRC_BLE       = 3'd2;
    localparam logic [2:0] SRC_LOCAL_JOB = 3'd4;

    localparam logic [31:0] REV_ANY       = 32'hFFFF_FFFF;
    localparam logic [21:0] TIMEOUT_RESET = 22'd30000;

    // Remaining-time saturation, in us and in ms
    localparam logic [63:0] REMAIN_MAX_US = 64'd3600000000;
    localparam logic [21:0] REMAIN_MAX_MS = 22'd3600000;

    // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for x below 4.9e9
    localparam logic [28:0] RECIP_1000  = 29'd274877907;
    localparam int          RECIP_SHIFT = 38;

    // Input payload, last declared field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [62:0] now_us;
        logic [63:0] fresh_low;
        logic [63:0] fresh_high;
        logic [63:0] token_low;
        logic [63:0] token_high;
        logic        token_given;
        logic [31:0] want_rev;
        logic        takeover;
        logic [2:0]  source;
    } req_t;

    // Output payload, last declared field in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [21:0] remaining_ms;
        logic        lease_expired;
        logic        lease_present;
        logic [63:0] token_out_low;
        logic [63:0] token_out_high;
        logic        token_out_valid;
        logic [31:0] revision_now;
        logic [2:0]  owner_now;
        logic [2:0]  status;
    } rsp_t;

    // Decision result plus post-step lease timing
    typedef struct packed {
        status_e_t   status;
        logic [2:0]  owner_now;
        logic [31:0] revision_now;
        logic        token_out_valid;
        logic [63:0] token_out_high;
        logic [63:0] token_out_low;
        logic        lease_present;
        logic [63:0] deadline_us;
        logic [62:0] now_us;
    } step_t;

    // Time-to-deadline summary
    typedef struct packed {
        logic        expired;
        logic        pos;
        logic        sat;
        logic [31:0] diff_us;
    } span_t;

endpackage

`default_nettype wire

>>> design/colla_core.sv
// Ownership state, lease state and per-request decision logic.
`default_nettype none

module colla_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [21:0]        cfg_wdata,
    input  wire logic               fire,
    input  wire colla_pkg::op_e_t   op,
    input  wire colla_pkg::req_t    req,
    output colla_pkg::step_t        step
);

    // Architectural state
    logic [31:0] timeout_us_reg;
    logic [2:0]  owner_reg,    owner_next;
    logic [31:0] revision_reg, revision_next;
    logic        held_reg,     held_next;
    logic [63:0] tok_hi_reg,   tok_hi_next;
    logic [63:0] tok_lo_reg,   tok_lo_next;
    logic [63:0] deadline_reg, deadline_next;

    logic        live, match, rev_ok, src_remote, keep;
    logic [31:0] rev_inc;
    logic [63:0] new_deadline;
    colla_pkg::status_e_t status;
    logic        tv;
    logic [63:0] oh, ol;

    function automatic logic is_remote(input logic [2:0] s);
        is_remote = (s == colla_pkg::SRC_REST) || (s == colla_pkg::SRC_BLE);
    endfunction

    // Shared checks
    assign live       = held_reg && ({1'b0, req.now_us} <= deadline_reg);
    assign match      = req.token_given && (req.token_high == tok_hi_reg)
                        && (req.token_low == tok_lo_reg);
    assign rev_ok     = (req.want_rev == colla_pkg::REV_ANY)
                        || (req.want_rev == revision_reg);
    assign src_remote = is_remote(req.source);
    assign keep       = (owner_reg == req.source) && src_remote && live;
    assign new_deadline = {1'b0, req.now_us} + {32'd0, timeout_us_reg};

    // Revision advance skips zero and the any-value
    always_comb begin
        rev_inc = revision_reg + 32'd1;
        if ((rev_inc == 32'd0) || (rev_inc == colla_pkg::REV_ANY)) begin
            rev_inc = 32'd1;
        end
    end

    // Request decision
    always_comb begin
        owner_next    = owner_reg;
        revision_next = revision_reg;
        held_next     = held_reg;
        tok_hi_next   = tok_hi_reg;
        tok_lo_next   = tok_lo_reg;
        deadline_next = deadline_reg;
        status        = colla_pkg::ST_NOT_OWNER;
        tv            = 1'b0;
        oh            = 64'd0;
        ol            = 64'd0;
        unique case (op)
            colla_pkg::OP_CLAIM: begin
                if ((req.source == colla_pkg::SRC_NONE)
                        || (req.source > colla_pkg::SRC_LOCAL_JOB)) begin
                    status = colla_pkg::ST_NOT_OWNER;
                end else if (!rev_ok) begin
                    status = colla_pkg::ST_STALE;
                end else if ((owner_reg != colla_pkg::SRC_NONE)
                        && (owner_reg != req.source) && !req.takeover) begin
                    status = colla_pkg::ST_BUSY;
                end else begin
                    owner_next    = req.source;
                    revision_next = rev_inc;
                    status        = colla_pkg::ST_OK;
                    if (!keep) begin
                        held_next     = src_remote;
                        tok_hi_next   = src_remote ? req.fresh_high : 64'd0;
                        tok_lo_next   = src_remote ? req.fresh_low : 64'd0;
                        deadline_next = src_remote ? new_deadline : 64'd0;
                    end
                    if (src_remote) begin
                        tv = 1'b1;
                        oh = keep ? tok_hi_reg : req.fresh_high;
                        ol = keep ? tok_lo_reg : req.fresh_low;
                    end
                end
            end
            colla_pkg::OP_AUTHORIZE: begin
                if (!rev_ok) begin
                    status = colla_pkg::ST_STALE;
                end else if (owner_reg != req.source) begin
                    status = colla_pkg::ST_NOT_OWNER;
                end else if (src_remote && !(live && match)) begin
                    status = colla_pkg::ST_INVALID;
                end else begin
                    status        = colla_pkg::ST_OK;
                    revision_next = rev_inc;
                end
            end
            colla_pkg::OP_HEARTBEAT: begin
                if (!src_remote || (owner_reg != req.source)) begin
                    status = colla_pkg::ST_NOT_OWNER;
                end else if (live && match) begin
                    status        = colla_pkg::ST_OK;
                    deadline_next = new_deadline;
                end else begin
                    status = colla_pkg::ST_INVALID;
                end
            end
            colla_pkg::OP_RELEASE: begin
                owner_next    = colla_pkg::SRC_NONE;
                held_next     = 1'b0;
                tok_hi_next   = 64'd0;
                tok_lo_next   = 64'd0;
                deadline_next = 64'd0;
                revision_next = rev_inc;
                status        = colla_pkg::ST_OK;
            end
            colla_pkg::OP_QUERY: begin
                status = colla_pkg::ST_OK;
                if ((owner_reg == req.source) && src_remote && held_reg) begin
                    tv = 1'b1;
                    oh = tok_hi_reg;
                    ol = tok_lo_reg;
                end
            end
            default: begin
                status = colla_pkg::ST_NOT_OWNER;
            end
        endcase
    end

    // Post-step view
    always_comb begin
        step.status          = status;
        step.owner_now       = owner_next;
        step.revision_now    = revision_next;
        step.token_out_valid = tv;
        step.token_out_high  = oh;
        step.token_out_low   = ol;
        step.lease_present   = is_remote(owner_next) && held_next;
        step.deadline_us     = deadline_next;
        step.now_us          = req.now_us;
    end

    // Timeout held in microseconds: t*1024 - t*16 - t*8
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_us_reg <= {colla_pkg::TIMEOUT_RESET, 10'd0}
                              - {6'd0, colla_pkg::TIMEOUT_RESET, 4'd0}
                              - {7'd0, colla_pkg::TIMEOUT_RESET, 3'd0};
        end else if (cfg_we) begin
            timeout_us_reg <= {cfg_wdata, 10'd0} - {6'd0, cfg_wdata, 4'd0}
                              - {7'd0, cfg_wdata, 3'd0};
        end
    end

    // State update when a request leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_reg    <= colla_pkg::SRC_NONE;
            revision_reg <= 32'd0;
            held_reg     <= 1'b0;
            tok_hi_reg   <= 64'd0;
            tok_lo_reg   <= 64'd0;
            deadline_reg <= 64'd0;
        end else if (fire) begin
            owner_reg    <= owner_next;
            revision_reg <= revision_next;
            held_reg     <= held_next;
            tok_hi_reg   <= tok_hi_next;
            tok_lo_reg   <= tok_lo_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule

`default_nettype wire

>>> design/colla_span.sv
// Deadline versus current time: expiry, sign and saturation of the gap.
`default_nettype none

module colla_span (
    input  wire logic             active,
    input  wire logic [63:0]      deadline_us,
    input  wire logic [62:0]      now_us,
    output colla_pkg::span_t      span
);

    logic [64:0] gap;

    // One subtract: borrow means now is past the deadline
    assign gap = {1'b0, deadline_us} - {2'b00, now_us};

    always_comb begin
        span.expired = active && gap[64];
        span.pos     = active && !gap[64] && (gap[63:0] != 64'd0);
        span.sat     = gap[63:0] >= colla_pkg::REMAIN_MAX_US;
        span.diff_us = gap[31:0];
    end

endmodule

`default_nettype wire

>>> design/colla_msdiv.sv
// Microseconds to whole milliseconds by reciprocal multiply, with saturation.
`default_nettype none

module colla_msdiv (
    input  wire colla_pkg::span_t span,
    output logic [21:0]           remaining_ms
);

    logic [60:0] prod;

    // Gap is below 3.6e9 when not saturated, inside the reciprocal's range
    assign prod = {29'd0, span.diff_us} * {32'd0, colla_pkg::RECIP_1000};

    always_comb begin
        if (!span.pos) begin
            remaining_ms = 22'd0;
        end else if (span.sat) begin
            remaining_ms = colla_pkg::REMAIN_MAX_MS;
        end else begin
            remaining_ms = prod[colla_pkg::RECIP_SHIFT +: 22];
        end
    end

endmodule

`default_nettype wire

>>> design/control_ownership_lease_arbiter_core.sv
// Top level of the control ownership lease arbiter: pipeline and ports.
//
//  Channel   Dir  Valid/Ready          Payload
//  request   in   s_tvalid/s_tready    s_tuser = op, s_tdata = req_t (360 b)
//  result    out  m_tvalid/m_tready    m_tdata = rsp_t (192 b)
//  config    in   cfg_we               cfg_wdata = lease_timeout_ms
//
//  Four register stages: input, decision, time gap, result. One request per
//  cycle sustained while m_tready stays high; a request passes them in order.
//  Owner and lease state update as a request leaves the input register, so
//  each request sees every earlier one. Reset clears all valids and the state,
//  and sets the timeout to 30000 ms. A stall on m_tready holds each stage only
//  once the stage after it is full; empty stages keep accepting.
`default_nettype none

module control_ownership_lease_arbiter_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration
    input  wire logic         cfg_we,
    input  wire logic [21:0]  cfg_wdata,
    // Request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // source, takeover, want_rev, token_given, token_high,
    // token_low, fresh_high, fresh_low, now_us, zero pad
    input  wire logic [359:0] s_tdata,
    // op
    input  wire logic [2:0]   s_tuser,
    // Result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, owner_now, revision_now, token_out_valid, token_out_high,
    // token_out_low, lease_present, lease_expired, remaining_ms, zero pad
    output logic [191:0]      m_tdata
);

    // Stage valids and payloads
    logic                 in_vld_reg;
    colla_pkg::req_t      in_req_reg;
    colla_pkg::op_e_t     in_op_reg;
    logic                 a_vld_reg;
    colla_pkg::step_t     a_step_reg;
    logic                 b_vld_reg;
    colla_pkg::step_t     b_step_reg;
    colla_pkg::span_t     b_span_reg;
    logic                 m_vld_reg;
    colla_pkg::rsp_t      m_rsp_reg;

    logic                 rdy_in, rdy_a, rdy_b, rdy_m;
    colla_pkg::step_t     step;
    colla_pkg::span_t     span;
    logic [21:0]          remaining_ms;
    colla_pkg::rsp_t      rsp_next;

    // Backpressure chain: a stage loads when it is empty or draining
    assign rdy_m    = !m_vld_reg || m_tready;
    assign rdy_b    = !b_vld_reg || rdy_m;
    assign rdy_a    = !a_vld_reg || rdy_b;
    assign rdy_in   = !in_vld_reg || rdy_a;
    assign s_tready = rdy_in;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_rsp_reg;

    // Decision and state
    colla_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (in_vld_reg && rdy_a),
        .op        (in_op_reg),
        .req       (in_req_reg),
        .step      (step)
    );

    // Time gap on the post-step deadline
    colla_span u_span (
        .active      (a_step_reg.lease_present),
        .deadline_us (a_step_reg.deadline_us),
        .now_us      (a_step_reg.now_us),
        .span        (span)
    );

    // Remaining milliseconds
    colla_msdiv u_msdiv (
        .span         (b_span_reg),
        .remaining_ms (remaining_ms)
    );

    // Result assembly
    always_comb begin
        rsp_next.pad             = 1'b0;
        rsp_next.remaining_ms    = remaining_ms;
        rsp_next.lease_expired   = b_span_reg.expired;
        rsp_next.lease_present   = b_step_reg.lease_present;
        rsp_next.token_out_low   = b_step_reg.token_out_low;
        rsp_next.token_out_high  = b_step_reg.token_out_high;
        rsp_next.token_out_valid = b_step_reg.token_out_valid;
        rsp_next.revision_now    = b_step_reg.revision_now;
        rsp_next.owner_now       = b_step_reg.owner_now;
        rsp_next.status          = b_step_reg.status;
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            if (rdy_in) begin
                in_vld_reg <= s_tvalid;
            end
            if (rdy_a) begin
                a_vld_reg <= in_vld_reg;
            end
            if (rdy_b) begin
                b_vld_reg <= a_vld_reg;
            end
            if (rdy_m) begin
                m_vld_reg <= b_vld_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (rdy_in && s_tvalid) begin
            in_req_reg <= colla_pkg::req_t'(s_tdata);
            in_op_reg  <= colla_pkg::op_e_t'(s_tuser);
        end
        if (rdy_a && in_vld_reg) begin
            a_step_reg <= step;
        end
        if (rdy_b && a_vld_reg) begin
            b_step_reg <= a_step_reg;
            b_span_reg <= span;
        end
        if (rdy_m && b_vld_reg) begin
            m_rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

>>> design/colla_checker.sv
// Port-level checks on the arbiter's result channel, bound to the top level.
`default_nettype none

module colla_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [191:0] m_tdata
);

    colla_pkg::rsp_t rsp;
    assign rsp = colla_pkg::rsp_t'(m_tdata);

    // A held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Expiry only on an active lease, and then no time left
    a_expired: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && rsp.lease_expired
            |-> rsp.lease_present && (rsp.remaining_ms == 22'd0))
        else $error("expired lease reported inconsistently");

    // Remaining time only for an active lease, within the cap
    a_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (rsp.remaining_ms != 22'd0)
            |-> rsp.lease_present && (rsp.remaining_ms <= colla_pkg::REMAIN_MAX_MS))
        else $error("remaining time without an active lease");

    // No token bits without a token
    a_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !rsp.token_out_valid
            |-> (rsp.token_out_high == 64'd0) && (rsp.token_out_low == 64'd0))
        else $error("token bits set without a token");

endmodule

bind control_ownership_lease_arbiter_core colla_checker u_colla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
